[sv/rgbsob_pkg.sv]
// Package with the payload types, register indexes and constants of the Sobel edge block.
package rgbsob_pkg;

   localparam int PIX_W   = 8;
   localparam int COORD_W = 11;
   localparam int CFG_W   = 12;
   localparam int CSR_IDX_W = 8;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // Luma weights in units of 1/256, applied as (29B + 150G + 77R) >> 8.
   localparam logic [7:0] GRAY_COEF_B = 8'd29;
   localparam logic [7:0] GRAY_COEF_G = 8'd150;
   localparam logic [7:0] GRAY_COEF_R = 8'd77;
   localparam int         GRAY_SHIFT  = 8;

   localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 8'd0,
      CSR_FRAME_HEIGHT = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   magnitude;
      logic [COORD_W-1:0] center_row;
      logic [COORD_W-1:0] center_col;
      logic               frame_last;
   } rsp_type;

endpackage

[sv/rgbsob_line_mem.sv]
// Two line stores of gray values with one read and one write port each.
module rgbsob_line_mem
   import rgbsob_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_idx,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_idx,
   input  logic [PIX_W-1:0]             wr_upper,
   input  logic [PIX_W-1:0]             wr_middle,
   output logic [PIX_W-1:0]             rd_upper,
   output logic [PIX_W-1:0]             rd_middle
);

   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_upper_ff;
   logic [PIX_W-1:0] rd_middle_ff;

   // Read data is the old content when the same entry is written in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_idx]  <= wr_upper;
         middle_mem[wr_idx] <= wr_middle;
      end
      if (rd_en) begin
         rd_upper_ff  <= upper_mem[rd_idx];
         rd_middle_ff <= middle_mem[rd_idx];
      end
   end

   assign rd_upper  = rd_upper_ff;
   assign rd_middle = rd_middle_ff;

endmodule

[sv/rgbsob_window.sv]
// 3x3 window taps and the Sobel gradient magnitude of the window center.
module rgbsob_window
   import rgbsob_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic [PIX_W-1:0] top,
   input  logic [PIX_W-1:0] mid,
   input  logic [PIX_W-1:0] bot,
   output logic [PIX_W-1:0] magnitude
);

   // Taps 0..2 hold the left column, 3..5 the center column, each top, mid, bottom.
   logic [PIX_W-1:0] tap_ff [6];
   logic [PIX_W-1:0] tap_in [6];

   logic [PIX_W+1:0]        sum_top, sum_bot, sum_left, sum_right;
   logic signed [PIX_W+2:0] grad_v, grad_h;
   logic [PIX_W+1:0]        abs_v, abs_h;
   logic [PIX_W+2:0]        mag_sum;

   always_comb begin
      tap_in = tap_ff;
      if (shift) begin
         tap_in[0] = tap_ff[3];
         tap_in[1] = tap_ff[4];
         tap_in[2] = tap_ff[5];
         tap_in[3] = top;
         tap_in[4] = mid;
         tap_in[5] = bot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            tap_ff[i] <= '0;
         end
      end else begin
         tap_ff <= tap_in;
      end
   end

   always_comb begin
      sum_top   = (PIX_W+2)'(tap_ff[0]) + {1'b0, tap_ff[3], 1'b0} + (PIX_W+2)'(top);
      sum_bot   = (PIX_W+2)'(tap_ff[2]) + {1'b0, tap_ff[5], 1'b0} + (PIX_W+2)'(bot);
      sum_left  = (PIX_W+2)'(tap_ff[0]) + {1'b0, tap_ff[1], 1'b0} + (PIX_W+2)'(tap_ff[2]);
      sum_right = (PIX_W+2)'(top) + {1'b0, mid, 1'b0} + (PIX_W+2)'(bot);
      grad_v    = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
      grad_h    = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
      abs_v     = grad_v[PIX_W+2] ? (PIX_W+2)'(-grad_v) : grad_v[PIX_W+1:0];
      abs_h     = grad_h[PIX_W+2] ? (PIX_W+2)'(-grad_h) : grad_h[PIX_W+1:0];
      mag_sum   = (PIX_W+3)'(abs_v) + (PIX_W+3)'(abs_h);
      magnitude = (mag_sum > (PIX_W+3)'(MAG_SAT)) ? MAG_SAT : mag_sum[PIX_W-1:0];
   end

endmodule

[sv/rgb_gray_sobel_edge_top.sv]
// Top level of the Sobel edge magnitude block: position tracking, pipeline and registers.
// rsp_valid is registered; a result that waits on a stalled output holds off the input.
// Throughput otherwise: one pixel per cycle, set by the single read and single write port
// of each line store; an interior pixel gives one result transaction, a border pixel none.
// Reset (synchronous, active high) clears position, window taps and pipeline valid bits,
// and loads frame_width 640 and frame_height 480; the line stores keep their contents.
module rgb_gray_sobel_edge_top
   import rgbsob_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // Column and row counter widths, and widths that can also hold the clamped dimensions.
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int DIM_WC = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int DIM_HC = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

   // Configuration registers.
   logic [CFG_W-1:0] width_cfg_ff, width_cfg_in;
   logic [CFG_W-1:0] height_cfg_ff, height_cfg_in;

   // Position of the next pixel in the frame.
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;

   // Stage 1: the pixel whose line store read is in flight.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_result_ff;
   logic             s1_last_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_gray_ff;

   // Forwarding of a write that hit the entry read in the same cycle.
   logic             fwd_ff, fwd_in;
   logic [PIX_W-1:0] fwd_upper_ff;
   logic [PIX_W-1:0] fwd_middle_ff;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_payload_ff;

   logic             req_fire;
   logic             rsp_free;
   logic             s1_move;
   logic [DIM_WC-1:0] w_eff, w_cfg_ext, col_ext, col_inc;
   logic [DIM_HC-1:0] h_eff, h_cfg_ext, row_ext, row_inc;
   logic [COL_W-1:0] col_cur;
   logic [ROW_W-1:0] row_cur;
   logic             cur_result, cur_last;
   logic [2*PIX_W-1:0] gray_acc;
   logic [PIX_W-1:0] gray_cur;
   logic [PIX_W-1:0] rd_upper, rd_middle;
   logic [PIX_W-1:0] s1_top, s1_mid;
   logic [PIX_W-1:0] magnitude;
   logic [31:0]      row_minus1, col_minus1;

   // ---------------------------------------------------------------------------------
   // Configuration port. Writes are always taken; an unknown index is dropped.
   // ---------------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_cfg_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_cfg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Dimensions in use are clamped to 3 up to the parameter maximum.
   always_comb begin
      w_cfg_ext = DIM_WC'(width_cfg_ff);
      h_cfg_ext = DIM_HC'(height_cfg_ff);
      if (w_cfg_ext < DIM_WC'(3)) begin
         w_eff = DIM_WC'(3);
      end else if (w_cfg_ext > DIM_WC'(MAX_WIDTH)) begin
         w_eff = DIM_WC'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg_ext;
      end
      if (h_cfg_ext < DIM_HC'(3)) begin
         h_eff = DIM_HC'(3);
      end else if (h_cfg_ext > DIM_HC'(MAX_HEIGHT)) begin
         h_eff = DIM_HC'(MAX_HEIGHT);
      end else begin
         h_eff = h_cfg_ext;
      end
   end

   // ---------------------------------------------------------------------------------
   // Handshake. Stage 1 moves on unless it holds a result and the output register is
   // still full; a new transaction is taken whenever stage 1 is empty or moves on.
   // ---------------------------------------------------------------------------------
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && (!s1_result_ff || rsp_free);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------------------------
   // Gray conversion and position of the incoming pixel.
   // ---------------------------------------------------------------------------------
   always_comb begin
      gray_acc = (2*PIX_W)'(GRAY_COEF_B) * (2*PIX_W)'(req_payload.blue)
               + (2*PIX_W)'(GRAY_COEF_G) * (2*PIX_W)'(req_payload.green)
               + (2*PIX_W)'(GRAY_COEF_R) * (2*PIX_W)'(req_payload.red);
      gray_cur = gray_acc[GRAY_SHIFT +: PIX_W];
   end

   always_comb begin
      col_cur    = req_payload.frame_start ? '0 : col_count_ff;
      row_cur    = req_payload.frame_start ? '0 : row_count_ff;
      col_ext    = DIM_WC'(col_cur);
      row_ext    = DIM_HC'(row_cur);
      col_inc    = col_ext + DIM_WC'(1);
      row_inc    = row_ext + DIM_HC'(1);
      cur_result = (row_ext >= DIM_HC'(2)) && (col_ext >= DIM_WC'(2))
                && (row_ext < h_eff) && (col_ext < w_eff);
      cur_last   = (row_ext == h_eff - DIM_HC'(1)) && (col_ext == w_eff - DIM_WC'(1));

      // A position past the end of a shrunken frame wraps the same way as the last one.
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_fire) begin
         if (col_inc >= w_eff) begin
            col_count_in = '0;
            row_count_in = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_count_in = col_inc[COL_W-1:0];
            row_count_in = (row_ext >= h_eff) ? '0 : row_cur;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Line stores. Each accepted pixel reads its column; when it leaves stage 1 the
   // middle value moves to the upper store and its gray value goes to the middle store.
   // ---------------------------------------------------------------------------------
   rgbsob_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock     (clock),
      .rd_en     (req_fire),
      .rd_idx    (col_cur),
      .wr_en     (s1_move),
      .wr_idx    (s1_col_ff),
      .wr_upper  (s1_mid),
      .wr_middle (s1_gray_ff),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle)
   );

   // A read and a write to the same column in one cycle happen when a frame-start pixel
   // directly follows a pixel in column 0; the read then returns stale data, so the
   // written values are captured and used in its place.
   always_comb begin
      s1_top = fwd_ff ? fwd_upper_ff : rd_upper;
      s1_mid = fwd_ff ? fwd_middle_ff : rd_middle;
      if (req_fire) begin
         fwd_in = s1_move && (col_cur == s1_col_ff);
      end else if (s1_move) begin
         fwd_in = 1'b0;
      end else begin
         fwd_in = fwd_ff;
      end
      s1_valid_in = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   end

   // Window taps and gradient magnitude of the window centered one row up, one left.
   rgbsob_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift     (s1_move),
      .top       (s1_top),
      .mid       (s1_mid),
      .bot       (s1_gray_ff),
      .magnitude (magnitude)
   );

   // ---------------------------------------------------------------------------------
   // Output register. It loads when stage 1 holds a result and the register is free.
   // ---------------------------------------------------------------------------------
   assign rsp_valid_in = rsp_free ? (s1_valid_ff && s1_result_ff) : rsp_valid_ff;
   assign row_minus1   = 32'(s1_row_ff) - 32'd1;
   assign col_minus1   = 32'(s1_col_ff) - 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= FRAME_WIDTH_RESET;
         height_cfg_ff <= FRAME_HEIGHT_RESET;
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         col_count_ff  <= col_count_in;
         row_count_ff  <= row_count_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_ff        <= fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_result_ff  <= cur_result;
         s1_last_ff    <= cur_last;
         s1_row_ff     <= row_cur;
         s1_col_ff     <= col_cur;
         s1_gray_ff    <= gray_cur;
         fwd_upper_ff  <= s1_mid;
         fwd_middle_ff <= s1_gray_ff;
      end
      if (rsp_free && s1_valid_ff && s1_result_ff) begin
         rsp_payload_ff.magnitude  <= magnitude;
         rsp_payload_ff.center_row <= row_minus1[COORD_W-1:0];
         rsp_payload_ff.center_col <= col_minus1[COORD_W-1:0];
         rsp_payload_ff.frame_last <= s1_last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   // A forwarded value only ever belongs to the transaction held in stage 1.
   a_fwd_in_stage1: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("forwarding flag set with stage 1 empty");

   // Input is held off only while stage 1 waits on a full, stalled output register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_result_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

   // A result is only produced for an interior window.
   a_result_interior: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_result_ff) |-> (s1_row_ff >= ROW_W'(2) && s1_col_ff >= COL_W'(2)))
      else $error("result produced for a border pixel");
`endif

endmodule
